/* rtl/ipv4_dotted_string_check_unit_defines.svh */
// Assertion macros shared by the dotted IPv4 checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef IPV4_DOTTED_STRING_CHECK_UNIT_DEFINES_SVH
`define IPV4_DOTTED_STRING_CHECK_UNIT_DEFINES_SVH

// Same-cycle property, sampled on the rising clock edge, off during reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipv4chk_pkg.sv */
// Types and constants for the dotted IPv4 string checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ipv4chk_pkg;

    localparam logic [7:0] C_CHAR_ZERO     = 8'h30;
    localparam logic [7:0] C_CHAR_NINE     = 8'h39;
    localparam logic [7:0] C_CHAR_DOT      = 8'h2E;
    localparam logic [7:0] C_MAX_VALUE     = 8'd255;
    localparam logic [1:0] C_MAX_DIGITS    = 2'd3;
    localparam logic [1:0] C_LAST_PART     = 2'd3;
    localparam logic [4:0] C_MAX_LEN       = 5'd15;
    localparam logic [4:0] C_COUNT_SAT     = 5'd16;

    // One input item as held in the input register.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } t_item;

endpackage

/* rtl/ipv4chk_parse.sv */
// Parser state and per-byte next-state logic of the dotted IPv4 checker.
// Depends on ipv4chk_pkg and the shared assertion macros header.
`timescale 1ns / 1ps
`include "ipv4_dotted_string_check_unit_defines.svh"

module ipv4chk_parse
    import ipv4chk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    output logic  o_verdict
);

    logic [1:0]  r_part_index, n_part_index;
    logic [1:0]  r_digits,     n_digits;
    logic [7:0]  r_part_value, n_part_value;
    logic [4:0]  r_byte_count, n_byte_count;
    logic        r_failed,     n_failed;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [11:0] acc_val;

    assign is_digit  = (i_item.text_byte >= C_CHAR_ZERO) && (i_item.text_byte <= C_CHAR_NINE);
    assign digit_val = i_item.text_byte[3:0];
    // part_value * 10 + digit, wide enough for 255 * 10 + 9
    assign acc_val   = {1'b0, r_part_value, 3'b000} + {3'b000, r_part_value, 1'b0}
                       + {8'd0, digit_val};

    assign o_verdict = !r_failed && (r_byte_count <= C_MAX_LEN)
                       && (r_part_index == C_LAST_PART) && (r_digits != 2'd0);

    always_comb begin
        n_part_index = r_part_index;
        n_digits     = r_digits;
        n_part_value = r_part_value;
        n_byte_count = r_byte_count;
        n_failed     = r_failed;
        if (i_item.end_marker) begin
            // verdict taken this cycle; start a fresh string
            n_part_index = '0;
            n_digits     = '0;
            n_part_value = '0;
            n_byte_count = '0;
            n_failed     = 1'b0;
        end else begin
            if (r_byte_count < C_COUNT_SAT) begin
                n_byte_count = r_byte_count + 5'd1;
            end
            if (!r_failed) begin
                if (is_digit) begin
                    if (r_digits >= C_MAX_DIGITS) begin
                        n_failed = 1'b1;
                    end else if (acc_val > {4'd0, C_MAX_VALUE}) begin
                        n_failed = 1'b1;
                    end else begin
                        n_part_value = acc_val[7:0];
                        n_digits     = r_digits + 2'd1;
                    end
                end else if (i_item.text_byte == C_CHAR_DOT) begin
                    if ((r_digits == 2'd0) || (r_part_index >= C_LAST_PART)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_part_index = r_part_index + 2'd1;
                        n_digits     = '0;
                        n_part_value = '0;
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_index <= '0;
            r_digits     <= '0;
            r_part_value <= '0;
            r_byte_count <= '0;
            r_failed     <= 1'b0;
        end else if (i_fire) begin
            r_part_index <= n_part_index;
            r_digits     <= n_digits;
            r_part_value <= n_part_value;
            r_byte_count <= n_byte_count;
            r_failed     <= n_failed;
        end
    end

    `CHK_NEXT(a_end_clears, i_clk, i_rst_n, i_fire && i_item.end_marker,
        (r_byte_count == 5'd0) && !r_failed && (r_part_index == 2'd0) && (r_digits == 2'd0),
        "end item did not clear parser state")
    `CHK_ALWAYS(a_count_sat, i_clk, i_rst_n, r_byte_count <= C_COUNT_SAT,
        "byte count ran past saturation")
    `CHK_ALWAYS(a_empty_part_zero, i_clk, i_rst_n, (r_digits != 2'd0) || (r_part_value == 8'd0),
        "part value nonzero with no digits")

endmodule

/* rtl/ipv4chk_out_stage.sv */
// Result register of the dotted IPv4 checker: holds one verdict until taken.
// Depends on ipv4chk_pkg.
`timescale 1ns / 1ps

module ipv4chk_out_stage
    import ipv4chk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_verdict,
    input  logic i_out_ready,
    output logic o_free,
    output logic o_out_valid,
    output logic o_address_valid
);

    logic r_valid;
    logic r_bit;

    assign o_free          = !r_valid || i_out_ready;
    assign o_out_valid     = r_valid;
    assign o_address_valid = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_verdict;
        end
    end

endmodule

/* rtl/ipv4_dotted_string_check_unit.sv */
// Dotted IPv4 checker: an end item enters the input register; its verdict then goes to o_out_*.
// One item per cycle: data bytes every clock, end items only when the result register is free.
// Rate is set by the single parser state update between input and result registers.
// Synchronous active-low reset empties both registers and zeroes the parser state.
// Depends on ipv4chk_pkg, ipv4chk_parse, ipv4chk_out_stage and the macros header.
`timescale 1ns / 1ps
`include "ipv4_dotted_string_check_unit_defines.svh"

module ipv4_dotted_string_check_unit
    import ipv4chk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_marker,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_address_valid
);

    // Input register: one item waiting for the parser.
    logic  r_in_valid;
    t_item r_in_item;

    logic  out_free;
    logic  drain;
    logic  verdict;
    logic  out_load;

    // A data byte always drains; an end item drains only if the result
    // register can take its verdict in the same edge.
    assign drain      = r_in_valid && (!r_in_item.end_marker || out_free);
    assign out_load   = drain && r_in_item.end_marker;
    // Accept a new item when the input register is empty or the held one leaves this cycle.
    assign o_in_ready = !r_in_valid || drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (drain) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: no reset needed, load on accept.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item.text_byte  <= i_text_byte;
            r_in_item.end_marker <= i_end_marker;
        end
    end

    // Advance the parser state by the held item.
    ipv4chk_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (drain),
        .i_item    (r_in_item),
        .o_verdict (verdict)
    );

    // Hold the verdict until the consumer takes it.
    ipv4chk_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (out_load),
        .i_verdict       (verdict),
        .i_out_ready     (i_out_ready),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .o_address_valid (o_address_valid)
    );

    `CHK_NEXT(a_end_gives_result, i_clk, i_rst_n, out_load, o_out_valid,
        "end item drained without a result")
    `CHK_ALWAYS(a_blocked_only_on_end, i_clk, i_rst_n,
        o_in_ready || (r_in_valid && r_in_item.end_marker && o_out_valid),
        "input stalled without a pending end item")
    `CHK_NEXT(a_data_no_result, i_clk, i_rst_n,
        drain && !r_in_item.end_marker && !o_out_valid, !o_out_valid,
        "data byte produced a result")

endmodule
